// ===== rtl/core/osu_pkg.sv =====
// ----------------------------------------------------------------------------
// osu_pkg
// Opcodes, status codes and controller states shared by the operand stack
// unit and its checker.
// ----------------------------------------------------------------------------
package osu_pkg;

    // stack operations carried in the input tuser
    typedef enum logic [2:0] {
        OP_NOP  = 3'd0,
        OP_PUSH = 3'd1,
        OP_POP  = 3'd2,
        OP_PEEK = 3'd3,
        OP_ADD  = 3'd4,
        OP_MUL  = 3'd5,
        OP_SWAP = 3'd6,
        OP_DUP  = 3'd7
    } t_op;

    // result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_NEED2    = 2'd3
    } t_status;

    // controller states, one-hot
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_READ  = 5'b00010,
        S_SWAP2 = 5'b00100,
        S_MUL   = 5'b01000,
        S_FIN   = 5'b10000
    } t_state;

    // fixed field widths of the stream channels
    localparam int unsigned OPCODE_W = 3;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned DEPTH_W  = 9;
    localparam int unsigned OUT_DATA_W = 48;

endpackage

// ===== rtl/core/osu_mem.sv =====
// ----------------------------------------------------------------------------
// osu_mem
// Stack word store: one write port and two registered read ports.
// ----------------------------------------------------------------------------
module osu_mem #(
    parameter int unsigned DEPTH = 256,
    parameter int unsigned WW    = 32,
    parameter int unsigned AW    = 8
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_wa,
    input  logic [WW-1:0] i_wd,
    input  logic [AW-1:0] i_ra0,
    input  logic [AW-1:0] i_ra1,
    output logic [WW-1:0] o_rd0,
    output logic [WW-1:0] o_rd1
);

    logic [WW-1:0] r_mem [DEPTH];
    logic [WW-1:0] r_rd0;
    logic [WW-1:0] r_rd1;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // read ports, registered
    always_ff @(posedge i_clk) begin
        r_rd0 <= r_mem[i_ra0];
        r_rd1 <= r_mem[i_ra1];
    end

    assign o_rd0 = r_rd0;
    assign o_rd1 = r_rd1;

endmodule

// ===== rtl/core/osu_mul.sv =====
// ----------------------------------------------------------------------------
// osu_mul
// Iterative multiplier: one 8-bit digit of the second operand per cycle,
// product kept modulo the word width.
// ----------------------------------------------------------------------------
module osu_mul #(
    parameter int unsigned WW = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [WW-1:0] i_a,
    input  logic [WW-1:0] i_b,
    output logic          o_done,
    output logic [WW-1:0] o_prod
);

    localparam int unsigned DIGIT = 8;
    localparam int unsigned STEPS = (WW + DIGIT - 1) / DIGIT;
    localparam int unsigned CW    = $clog2(STEPS + 1);

    logic [WW-1:0]       r_acc;
    logic [WW-1:0]       r_a;
    logic [WW-1:0]       r_b;
    logic [CW-1:0]       r_cnt;
    logic                r_busy;
    logic                r_done;
    logic [WW+DIGIT-1:0] w_pp;

    // partial product of the shifted multiplicand and the current digit
    assign w_pp = {{DIGIT{1'b0}}, r_a} * {{WW{1'b0}}, r_b[DIGIT-1:0]};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CW'(1);
            if (r_cnt == CW'(STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= '0;
            r_a   <= i_a;
            r_b   <= i_b;
        end else if (r_busy) begin
            r_acc <= r_acc + w_pp[WW-1:0];
            r_a   <= r_a << DIGIT;
            r_b   <= r_b >> DIGIT;
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

// ===== rtl/core/operand_stack_unit.sv =====
// ----------------------------------------------------------------------------
// operand_stack_unit
// Operand stack of a small stack machine, words held in a synchronous memory.
// ----------------------------------------------------------------------------
// One operation is worked at a time; the input is ready again once its result
// is loaded into the output register. Nop, push and every error go straight to
// the finish state; pop, peek, duplicate and add first read the top two words
// from memory, then duplicate and add write back; swap makes two writes through
// the single write port, and multiply waits on the 8-bit-digit iterative
// multiplier. A stalled output holds the last operation in its final state
// until the result is taken. Stack words need no clearing after reset: only
// entries below the top pointer are ever used.
module operand_stack_unit
    import osu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256,
    parameter int unsigned WORD_WIDTH  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [VALUE_W-1:0]    i_s_tdata,   // [31:0] push_value
    input  logic [OPCODE_W-1:0]   i_s_tuser,   // [2:0] opcode
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,   // [31:0] read_value, [40:32] stack_depth
    output logic [STATUS_W-1:0]   o_m_tuser    // [1:0] status
);

    localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned AW = $clog2(STACK_DEPTH);
    localparam int unsigned WW = WORD_WIDTH;

    t_state            r_state,  n_state;
    t_op               r_op,     n_op;
    t_status           r_status, n_status;
    logic [WW-1:0]     r_pv,     n_pv;
    logic [WW-1:0]     r_swap,   n_swap;
    logic [VALUE_W-1:0] r_res,   n_res;
    logic [PW-1:0]     r_top,    n_top;
    logic              r_m_valid, n_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data, n_m_data;
    logic [STATUS_W-1:0]   r_m_user, n_m_user;

    logic [PW-1:0] w_tm1;
    logic [PW-1:0] w_tm2;
    logic          w_full;
    logic          w_empty;
    logic          w_lt2;
    logic          w_accept;
    logic          w_we;
    logic [AW-1:0] w_wa;
    logic [WW-1:0] w_wd;
    logic [WW-1:0] w_rd0;
    logic [WW-1:0] w_rd1;
    logic          w_mul_start;
    logic          w_mul_done;
    logic [WW-1:0] w_prod;
    t_op           w_in_op;

    // pointer arithmetic and occupancy flags
    assign w_tm1   = r_top - PW'(1);
    assign w_tm2   = r_top - PW'(2);
    assign w_full  = (r_top == PW'(STACK_DEPTH));
    assign w_empty = (r_top == '0);
    assign w_lt2   = (r_top < PW'(2));
    assign w_in_op = t_op'(i_s_tuser);

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // word store, read at the top two entries every cycle
    osu_mem #(
        .DEPTH (STACK_DEPTH),
        .WW    (WW),
        .AW    (AW)
    ) u_mem (
        .i_clk (i_clk),
        .i_we  (w_we),
        .i_wa  (w_wa),
        .i_wd  (w_wd),
        .i_ra0 (w_tm1[AW-1:0]),
        .i_ra1 (w_tm2[AW-1:0]),
        .o_rd0 (w_rd0),
        .o_rd1 (w_rd1)
    );

    osu_mul #(
        .WW (WW)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mul_start),
        .i_a     (w_rd0),
        .i_b     (w_rd1),
        .o_done  (w_mul_done),
        .o_prod  (w_prod)
    );

    // sequencer: check, read, modify, write back, deliver
    always_comb begin
        n_state     = r_state;
        n_op        = r_op;
        n_status    = r_status;
        n_pv        = r_pv;
        n_swap      = r_swap;
        n_res       = r_res;
        n_top       = r_top;
        n_m_valid   = r_m_valid && !i_m_tready;
        n_m_data    = r_m_data;
        n_m_user    = r_m_user;
        w_we        = 1'b0;
        w_wa        = r_top[AW-1:0];
        w_wd        = r_pv;
        w_mul_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_op     = w_in_op;
                    n_pv     = WW'(signed'(i_s_tdata));
                    n_res    = '0;
                    n_status = ST_OK;
                    n_state  = S_FIN;
                    case (w_in_op)
                        OP_PUSH: begin
                            if (w_full) begin
                                n_status = ST_OVERFLOW;
                            end else begin
                                w_we  = 1'b1;
                                w_wa  = r_top[AW-1:0];
                                w_wd  = WW'(signed'(i_s_tdata));
                                n_top = r_top + PW'(1);
                            end
                        end
                        OP_POP, OP_PEEK: begin
                            if (w_empty) n_status = ST_EMPTY;
                            else         n_state  = S_READ;
                        end
                        OP_ADD, OP_MUL, OP_SWAP: begin
                            if (w_lt2) n_status = ST_NEED2;
                            else       n_state  = S_READ;
                        end
                        OP_DUP: begin
                            if (w_full)       n_status = ST_OVERFLOW;
                            else if (w_empty) n_status = ST_EMPTY;
                            else              n_state  = S_READ;
                        end
                        default: begin
                            n_status = ST_OK;
                        end
                    endcase
                end
            end
            S_READ: begin
                n_state = S_FIN;
                case (r_op)
                    OP_POP: begin
                        n_res = VALUE_W'(signed'(w_rd0));
                        n_top = w_tm1;
                    end
                    OP_PEEK: begin
                        n_res = VALUE_W'(signed'(w_rd0));
                    end
                    OP_DUP: begin
                        w_we  = 1'b1;
                        w_wa  = r_top[AW-1:0];
                        w_wd  = w_rd0;
                        n_top = r_top + PW'(1);
                    end
                    OP_ADD: begin
                        w_we  = 1'b1;
                        w_wa  = w_tm2[AW-1:0];
                        w_wd  = w_rd0 + w_rd1;
                        n_top = w_tm1;
                    end
                    OP_SWAP: begin
                        w_we    = 1'b1;
                        w_wa    = w_tm1[AW-1:0];
                        w_wd    = w_rd1;
                        n_swap  = w_rd0;
                        n_state = S_SWAP2;
                    end
                    OP_MUL: begin
                        w_mul_start = 1'b1;
                        n_state     = S_MUL;
                    end
                    default: begin
                        n_state = S_FIN;
                    end
                endcase
            end
            S_SWAP2: begin
                // old top goes one below
                w_we    = 1'b1;
                w_wa    = w_tm2[AW-1:0];
                w_wd    = r_swap;
                n_state = S_FIN;
            end
            S_MUL: begin
                if (w_mul_done) begin
                    w_we    = 1'b1;
                    w_wa    = w_tm2[AW-1:0];
                    w_wd    = w_prod;
                    n_top   = w_tm1;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // load the output register once it is free
                if (!r_m_valid || i_m_tready) begin
                    n_m_valid = 1'b1;
                    n_m_data  = {7'd0, DEPTH_W'(r_top), r_res};
                    n_m_user  = r_status;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_top     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_top     <= n_top;
            r_m_valid <= n_m_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_status <= n_status;
        r_pv     <= n_pv;
        r_swap   <= n_swap;
        r_res    <= n_res;
        r_m_data <= n_m_data;
        r_m_user <= n_m_user;
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;
    assign o_m_tuser  = r_m_user;

endmodule

// ===== rtl/core/osu_checker.sv =====
// ----------------------------------------------------------------------------
// osu_checker
// Port-level checks of the operand stack unit, bound to the top level.
// ----------------------------------------------------------------------------
module osu_checker
    import osu_pkg::*;
#(
    parameter int unsigned STACK_DEPTH = 256
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  i_s_tready,
    input logic                  i_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] i_m_tdata,
    input logic [STATUS_W-1:0]   i_m_tuser
);

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid && $stable(i_m_tdata)
            && $stable(i_m_tuser))
        else $error("result changed while stalled");

    // errors give a zero word; non-read operations do too, but only errors are checked
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != ST_OK) |-> (i_m_tdata[VALUE_W-1:0] == '0))
        else $error("error status with nonzero read value");

    // reported depth stays within the stack
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (32'(i_m_tdata[VALUE_W+DEPTH_W-1:VALUE_W]) <= STACK_DEPTH))
        else $error("depth beyond stack size");

    // one operation at a time
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input ready right after an accepted item");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

endmodule

bind operand_stack_unit osu_checker #(
    .STACK_DEPTH (STACK_DEPTH)
) u_osu_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .i_s_tready (o_s_tready),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tuser  (o_m_tuser)
);
